[rtl/core/dbb_pkg.sv]
package dbb_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int DEPTH_W        = 16;
    localparam int OUT_W          = 24;
    localparam int CNT_W          = 24;
    localparam int FOCAL_W        = 24;
    localparam int UF_W           = FOCAL_W + DEPTH_W;
    localparam int QUEUE_DEPTH    = 4;

    localparam int CFG_DW = 64;
    localparam int CFG_AW = 6;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic CMD_BOX   = 1'b0;
    localparam logic CMD_DEPTH = 1'b1;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_SUM   = 1'b1;

    localparam logic [2:0] REG_PRINCIPAL = 3'd0;
    localparam logic [2:0] REG_INV_FX    = 3'd1;
    localparam logic [2:0] REG_INV_FY    = 3'd2;
    localparam logic [2:0] REG_XFORM0    = 3'd3;
    localparam logic [2:0] REG_XFORM1    = 3'd4;
    localparam logic [2:0] REG_XFORM2    = 3'd5;

    typedef struct packed {
        logic has_point;
        logic has_sum;
        logic sum_valid;
    } t_job_ctl;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_CALC = 3'b010,
        BK_EMIT = 3'b100
    } t_back_st;

endpackage

[rtl/core/dbb_in_if.sv]
interface dbb_in_if #(
    parameter int COORD_BITS = dbb_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [COORD_BITS-1:0] box_left;
    logic [COORD_BITS-1:0] box_top;
    logic [COORD_BITS-1:0] box_right;
    logic [COORD_BITS-1:0] box_bottom;
    logic [15:0]           depth_mm;

    modport source (
        output valid, command, box_left, box_top, box_right, box_bottom, depth_mm,
        input  ready
    );
    modport sink (
        input  valid, command, box_left, box_top, box_right, box_bottom, depth_mm,
        output ready
    );
endinterface

[rtl/core/dbb_out_if.sv]
interface dbb_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic               box_valid;
    logic               last;

    modport source (
        output valid, kind, point_x, point_y, point_z, box_valid, last,
        input  ready
    );
    modport sink (
        input  valid, kind, point_x, point_y, point_z, box_valid, last,
        output ready
    );
endinterface

[rtl/core/dbb_queue.sv]
module dbb_queue #(
    parameter int W     = 8,
    parameter int DEPTH = dbb_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_full,
    output logic         o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

[rtl/core/dbb_front.sv]
module dbb_front #(
    parameter int COORD_BITS = dbb_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    dbb_in_if.sink                   i_req,
    input  logic                     i_q_full,
    output logic                     o_push,
    output dbb_pkg::t_job_ctl        o_job_ctl,
    output logic [COORD_BITS-1:0]    o_job_col,
    output logic [COORD_BITS-1:0]    o_job_row,
    output logic [15:0]              o_job_depth
);
    import dbb_pkg::*;

    logic                  r_box_open, n_box_open;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] r_left, n_left;
    logic [COORD_BITS-1:0] r_right, n_right;
    logic [COORD_BITS-1:0] r_bottom, n_bottom;
    logic [CNT_W-1:0]      r_zero_cnt, n_zero_cnt;
    logic [CNT_W-1:0]      r_box_area, n_box_area;

    logic                    w_accept;
    logic                    w_neg_w, w_neg_h, w_zero_w, w_zero_h, w_neg_area;
    logic [COORD_BITS-1:0]   w_width, w_height;
    logic [2*COORD_BITS-1:0] w_area_full;
    logic                    w_final;
    logic [CNT_W-1:0]        w_zc_inc, w_zc_next;
    logic [CNT_W+2:0]        w_zc5, w_area3;

    assign i_req.ready = !i_q_full;
    assign w_accept    = i_req.valid && !i_q_full;

    assign w_neg_w    = i_req.box_right < i_req.box_left;
    assign w_neg_h    = i_req.box_bottom < i_req.box_top;
    assign w_zero_w   = i_req.box_right == i_req.box_left;
    assign w_zero_h   = i_req.box_bottom == i_req.box_top;
    assign w_neg_area = (w_neg_w != w_neg_h) && !w_zero_w && !w_zero_h;

    assign w_width     = i_req.box_right - i_req.box_left;
    assign w_height    = i_req.box_bottom - i_req.box_top;
    assign w_area_full = w_width * w_height;

    assign w_final   = (r_col == r_right) && (r_row == r_bottom);
    assign w_zc_inc  = (r_zero_cnt == CNT_MAX) ? r_zero_cnt : r_zero_cnt + 1'b1;
    assign w_zc_next = (i_req.depth_mm == '0) ? w_zc_inc : r_zero_cnt;
    assign w_zc5     = {1'b0, w_zc_next, 2'b00} + {3'b000, w_zc_next};
    assign w_area3   = {2'b00, r_box_area, 1'b0} + {3'b000, r_box_area};

    always_comb begin
        n_box_open  = r_box_open;
        n_col       = r_col;
        n_row       = r_row;
        n_left      = r_left;
        n_right     = r_right;
        n_bottom    = r_bottom;
        n_zero_cnt  = r_zero_cnt;
        n_box_area  = r_box_area;
        o_push      = 1'b0;
        o_job_ctl   = '0;
        o_job_col   = r_col;
        o_job_row   = r_row;
        o_job_depth = i_req.depth_mm;
        if (w_accept) begin
            if (i_req.command == CMD_BOX) begin
                n_box_open = 1'b0;
                if (w_neg_w || w_neg_h) begin
                    o_push              = 1'b1;
                    o_job_ctl.has_sum   = 1'b1;
                    o_job_ctl.sum_valid = !w_neg_area;
                end else begin
                    n_box_open = 1'b1;
                    n_col      = i_req.box_left;
                    n_row      = i_req.box_top;
                    n_left     = i_req.box_left;
                    n_right    = i_req.box_right;
                    n_bottom   = i_req.box_bottom;
                    n_zero_cnt = '0;
                    n_box_area = CNT_W'(w_area_full);
                end
            end else if (r_box_open) begin
                n_zero_cnt = w_zc_next;
                if (i_req.depth_mm != '0) begin
                    o_push              = 1'b1;
                    o_job_ctl.has_point = 1'b1;
                end
                if (w_final) begin
                    o_push              = 1'b1;
                    o_job_ctl.has_sum   = 1'b1;
                    o_job_ctl.sum_valid = !(w_zc5 > w_area3);
                    n_box_open          = 1'b0;
                end else if (r_col == r_right) begin
                    n_col = r_left;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_open <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_left     <= '0;
            r_right    <= '0;
            r_bottom   <= '0;
            r_zero_cnt <= '0;
            r_box_area <= '0;
        end else begin
            r_box_open <= n_box_open;
            r_col      <= n_col;
            r_row      <= n_row;
            r_left     <= n_left;
            r_right    <= n_right;
            r_bottom   <= n_bottom;
            r_zero_cnt <= n_zero_cnt;
            r_box_area <= n_box_area;
        end
    end
endmodule

[rtl/core/dbb_back.sv]
module dbb_back #(
    parameter int COORD_BITS = dbb_pkg::COORD_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_q_empty,
    input  dbb_pkg::t_job_ctl        i_job_ctl,
    input  logic [COORD_BITS-1:0]    i_job_col,
    input  logic [COORD_BITS-1:0]    i_job_row,
    input  logic [15:0]              i_job_depth,
    output logic                     o_pop,
    input  logic [31:0]              i_principal,
    input  logic [23:0]              i_inv_fx,
    input  logic [23:0]              i_inv_fy,
    input  logic [2:0][63:0]         i_xform,
    dbb_out_if.source                o_res
);
    import dbb_pkg::*;

    localparam int PIX_W = ((COORD_BITS + 4) > 16) ? (COORD_BITS + 4) : 16;
    localparam int DX_W  = PIX_W + 2;
    localparam int CAM_W = DX_W + 13;
    localparam int MA_W  = UF_W + 1;
    localparam int MB_W  = DX_W;
    localparam int P_W   = MA_W + MB_W;
    localparam int ACC_W = CAM_W + 18;
    localparam int Q_W   = ACC_W - 13;

    localparam logic [P_W-1:0]          RND28 = P_W'(1) << 27;
    localparam logic [ACC_W-1:0]        RND14 = ACC_W'(1) << 13;
    localparam logic signed [Q_W-1:0]   Q_MAX = Q_W'(8388607);
    localparam logic signed [Q_W-1:0]   Q_MIN = Q_W'(-8388608);
    localparam logic [3:0]              STEP_LAST = 4'd14;

    t_back_st                r_st;
    logic [3:0]              r_step;
    t_job_ctl                r_ctl;
    logic                    r_pend_pt, r_pend_sum;
    logic [DEPTH_W-1:0]      r_depth;
    logic signed [DX_W-1:0]  r_dx, r_dy;
    logic signed [P_W-1:0]   r_prod;
    logic signed [CAM_W-1:0] r_camx, r_camy;
    logic [ACC_W-1:0]        r_acc;
    logic [OUT_W-1:0]        r_res [3];

    logic                    r_out_valid;
    logic                    r_out_kind;
    logic [OUT_W-1:0]        r_out_x, r_out_y, r_out_z;
    logic                    r_out_bvalid;
    logic                    r_out_last;

    logic signed [MA_W-1:0]  w_a;
    logic signed [MB_W-1:0]  w_b;
    logic signed [P_W-1:0]   w_prod;
    logic [P_W-1:0]          w_rsum;
    logic signed [CAM_W-1:0] w_cam;
    logic signed [DX_W-1:0]  w_dx, w_dy;
    logic [15:0]             w_trans;
    logic signed [Q_W-1:0]   w_q;
    logic [OUT_W-1:0]        w_fin;
    logic                    w_out_free;

    function automatic logic signed [MB_W-1:0] rot_term(input logic [15:0] v);
        return {{(MB_W-16){v[15]}}, v};
    endfunction

    function automatic logic signed [MA_W-1:0] cam_term(input logic [CAM_W-1:0] v);
        return {{(MA_W-CAM_W){v[CAM_W-1]}}, v};
    endfunction

    assign w_dx = $signed({{(DX_W-COORD_BITS-4){1'b0}}, i_job_col, 4'b0000})
                - $signed({{(DX_W-16){1'b0}}, i_principal[15:0]});
    assign w_dy = $signed({{(DX_W-COORD_BITS-4){1'b0}}, i_job_row, 4'b0000})
                - $signed({{(DX_W-16){1'b0}}, i_principal[31:16]});

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (r_step)
            4'd0: begin
                w_a = {{(MA_W-FOCAL_W){1'b0}}, i_inv_fx};
                w_b = {{(MB_W-DEPTH_W){1'b0}}, r_depth};
            end
            4'd1: begin
                w_a = r_prod[MA_W-1:0];
                w_b = r_dx;
            end
            4'd2: begin
                w_a = {{(MA_W-FOCAL_W){1'b0}}, i_inv_fy};
                w_b = {{(MB_W-DEPTH_W){1'b0}}, r_depth};
            end
            4'd3: begin
                w_a = r_prod[MA_W-1:0];
                w_b = r_dy;
            end
            4'd4: begin
                w_a = {{(MA_W-DEPTH_W){1'b0}}, r_depth};
                w_b = rot_term(i_xform[0][47:32]);
            end
            4'd5: begin
                w_a = cam_term(r_camx);
                w_b = rot_term(i_xform[0][15:0]);
            end
            4'd6: begin
                w_a = cam_term(r_camy);
                w_b = rot_term(i_xform[0][31:16]);
            end
            4'd7: begin
                w_a = {{(MA_W-DEPTH_W){1'b0}}, r_depth};
                w_b = rot_term(i_xform[1][47:32]);
            end
            4'd8: begin
                w_a = cam_term(r_camx);
                w_b = rot_term(i_xform[1][15:0]);
            end
            4'd9: begin
                w_a = cam_term(r_camy);
                w_b = rot_term(i_xform[1][31:16]);
            end
            4'd10: begin
                w_a = {{(MA_W-DEPTH_W){1'b0}}, r_depth};
                w_b = rot_term(i_xform[2][47:32]);
            end
            4'd11: begin
                w_a = cam_term(r_camx);
                w_b = rot_term(i_xform[2][15:0]);
            end
            4'd12: begin
                w_a = cam_term(r_camy);
                w_b = rot_term(i_xform[2][31:16]);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod = w_a * w_b;

    // round half up from q.28
    assign w_rsum = r_prod + RND28;
    assign w_cam  = w_rsum[P_W-1:28];

    always_comb begin
        case (r_step)
            4'd8:    w_trans = i_xform[0][63:48];
            4'd11:   w_trans = i_xform[1][63:48];
            default: w_trans = i_xform[2][63:48];
        endcase
    end

    assign w_q = $signed({r_acc[ACC_W-1], r_acc[ACC_W-1:14]})
               + $signed({{(Q_W-16){w_trans[15]}}, w_trans});

    always_comb begin
        if (w_q > Q_MAX) begin
            w_fin = Q_MAX[OUT_W-1:0];
        end else if (w_q < Q_MIN) begin
            w_fin = Q_MIN[OUT_W-1:0];
        end else begin
            w_fin = w_q[OUT_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || o_res.ready;
    assign o_pop      = (r_st == BK_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_depth <= i_job_depth;
            r_dx    <= w_dx;
            r_dy    <= w_dy;
            r_ctl   <= i_job_ctl;
        end
        r_prod <= w_prod;
        if (r_step == 4'd2) begin
            r_camx <= w_cam;
        end
        if (r_step == 4'd4) begin
            r_camy <= w_cam;
        end
        case (r_step)
            4'd5, 4'd8, 4'd11: begin
                r_acc <= r_prod[ACC_W-1:0] + RND14;
            end
            4'd6, 4'd7, 4'd9, 4'd10, 4'd12, 4'd13: begin
                r_acc <= r_acc + r_prod[ACC_W-1:0];
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
        if (r_st == BK_CALC) begin
            if (r_step == 4'd8) begin
                r_res[0] <= w_fin;
            end
            if (r_step == 4'd11) begin
                r_res[1] <= w_fin;
            end
            if (r_step == STEP_LAST) begin
                r_res[2] <= w_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= BK_IDLE;
            r_step      <= '0;
            r_pend_pt   <= 1'b0;
            r_pend_sum  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_res.ready && (r_st != BK_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_st)
                BK_IDLE: begin
                    r_step <= '0;
                    if (o_pop) begin
                        r_pend_pt  <= i_job_ctl.has_point;
                        r_pend_sum <= i_job_ctl.has_sum;
                        r_st       <= i_job_ctl.has_point ? BK_CALC : BK_EMIT;
                    end
                end
                BK_CALC: begin
                    if (r_step == STEP_LAST) begin
                        r_step <= '0;
                        r_st   <= BK_EMIT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                BK_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_pend_pt) begin
                            r_out_kind   <= KIND_POINT;
                            r_out_x      <= r_res[0];
                            r_out_y      <= r_res[1];
                            r_out_z      <= r_res[2];
                            r_out_bvalid <= 1'b0;
                            r_out_last   <= !r_pend_sum;
                            r_pend_pt    <= 1'b0;
                            if (!r_pend_sum) begin
                                r_st <= BK_IDLE;
                            end
                        end else begin
                            r_out_kind   <= KIND_SUM;
                            r_out_x      <= '0;
                            r_out_y      <= '0;
                            r_out_z      <= '0;
                            r_out_bvalid <= r_ctl.sum_valid;
                            r_out_last   <= 1'b1;
                            r_pend_sum   <= 1'b0;
                            r_st         <= BK_IDLE;
                        end
                    end
                end
                default: begin
                    r_st <= BK_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.kind      = r_out_kind;
    assign o_res.point_x   = r_out_x;
    assign o_res.point_y   = r_out_y;
    assign o_res.point_z   = r_out_z;
    assign o_res.box_valid = r_out_bvalid;
    assign o_res.last      = r_out_last;
endmodule

[rtl/core/depth_box_backprojector.sv]
// channel   dir   payload                                          per request
// i_req     in    command, box_left/top/right/bottom, depth_mm     one box start or one sample
// o_res     out   kind, point_x/y/z, box_valid, last               one point or one box summary
// apb       in    psel, penable, pwrite, paddr, pwdata -> prdata   one register write or read
//
// front side takes one request per cycle while the job queue has room
// a point is computed in the back end on one shared multiplier in 13 steps, then its summary if it has one
// a summary alone skips the calculation in the back end; samples with no result push no job
// i_rst_n is synchronous; it clears scan state, queue, back end and output valid
// an output stall holds the back end and fills the queue; i_req.ready drops only once the queue is full
module depth_box_backprojector #(
    parameter int COORD_BITS = dbb_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dbb_in_if.sink                      i_req,
    dbb_out_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dbb_pkg::CFG_AW-1:0]  paddr,
    input  logic [dbb_pkg::CFG_DW-1:0]  pwdata,
    output logic [dbb_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);
    import dbb_pkg::*;

    localparam int JOB_W = $bits(t_job_ctl) + 2 * COORD_BITS + DEPTH_W;

    logic [31:0]      r_principal;
    logic [23:0]      r_inv_fx;
    logic [23:0]      r_inv_fy;
    logic [2:0][63:0] r_xform;

    logic [2:0]       w_reg_idx;
    logic             w_cfg_wr;

    logic                  w_push, w_pop, w_q_full, w_q_empty;
    t_job_ctl              w_f_ctl, w_b_ctl;
    logic [COORD_BITS-1:0] w_f_col, w_f_row, w_b_col, w_b_row;
    logic [DEPTH_W-1:0]    w_f_depth, w_b_depth;
    logic [JOB_W-1:0]      w_q_wdata, w_q_rdata;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[CFG_AW-1:3];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_principal <= '0;
            r_inv_fx    <= '0;
            r_inv_fy    <= '0;
            r_xform     <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_PRINCIPAL: r_principal <= pwdata[31:0];
                REG_INV_FX:    r_inv_fx    <= pwdata[23:0];
                REG_INV_FY:    r_inv_fy    <= pwdata[23:0];
                REG_XFORM0:    r_xform[0]  <= pwdata;
                REG_XFORM1:    r_xform[1]  <= pwdata;
                REG_XFORM2:    r_xform[2]  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_PRINCIPAL: prdata = {32'd0, r_principal};
            REG_INV_FX:    prdata = {40'd0, r_inv_fx};
            REG_INV_FY:    prdata = {40'd0, r_inv_fy};
            REG_XFORM0:    prdata = r_xform[0];
            REG_XFORM1:    prdata = r_xform[1];
            REG_XFORM2:    prdata = r_xform[2];
            default:       prdata = '0;
        endcase
    end

    dbb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_job_ctl   (w_f_ctl),
        .o_job_col   (w_f_col),
        .o_job_row   (w_f_row),
        .o_job_depth (w_f_depth)
    );

    assign w_q_wdata = {w_f_ctl, w_f_col, w_f_row, w_f_depth};
    assign {w_b_ctl, w_b_col, w_b_row, w_b_depth} = w_q_rdata;

    dbb_queue #(
        .W     (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_q_wdata),
        .i_pop   (w_pop),
        .o_rdata (w_q_rdata),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    dbb_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_job_ctl   (w_b_ctl),
        .i_job_col   (w_b_col),
        .i_job_row   (w_b_row),
        .i_job_depth (w_b_depth),
        .o_pop       (w_pop),
        .i_principal (r_principal),
        .i_inv_fx    (r_inv_fx),
        .i_inv_fy    (r_inv_fy),
        .i_xform     (r_xform),
        .o_res       (o_res)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("job queue read while empty");

    a_summary_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_SUM)) |->
            (o_res.last && (o_res.point_x == '0) && (o_res.point_y == '0)
             && (o_res.point_z == '0)))
        else $error("summary result without last or with a point");

    a_point_no_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.kind == KIND_POINT)) |-> !o_res.box_valid)
        else $error("point result carries box valid");
endmodule
